@@ src/abt_pkg.sv @@
// shared constants and types for the alpha-beta target tracker
`timescale 1ns / 1ps
package abt_pkg;

  localparam int IN_DATA_W  = 168;
  localparam int OUT_DATA_W = 312;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  localparam int WIDE_W = 64;
  localparam int MUL_B_W = 32;
  localparam int DIV_D_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GATE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 3'd4;

  localparam logic [1:0] TRK_TRACKING = 2'd0;
  localparam logic [1:0] TRK_COASTING = 2'd1;
  localparam logic [1:0] TRK_LOST     = 2'd2;

  typedef struct packed {
    logic start;
    logic done;
  } unit_hs_t;

endpackage

@@ src/abt_mul.sv @@
// bit-serial shift-add multiplier, one multiplier bit per cycle
`timescale 1ns / 1ps
module abt_mul (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [abt_pkg::WIDE_W-1:0]   a,
  input  logic [abt_pkg::MUL_B_W-1:0]  b,
  output logic                         done,
  output logic [abt_pkg::WIDE_W-1:0]   prod
);
  import abt_pkg::*;

  logic                busy;
  logic [4:0]          cnt;
  logic [WIDE_W-1:0]   ma;
  logic [MUL_B_W-1:0]  mb;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ma   <= a;
      mb   <= b;
      prod <= '0;
    end else if (busy) begin
      if (mb[0]) prod <= prod + ma;
      ma <= ma << 1;
      mb <= mb >> 1;
    end
  end

endmodule

@@ src/abt_div.sv @@
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module abt_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [abt_pkg::WIDE_W-1:0]   n,
  input  logic [abt_pkg::DIV_D_W-1:0]  d,
  output logic                         done,
  output logic [abt_pkg::WIDE_W-1:0]   q
);
  import abt_pkg::*;

  logic                busy;
  logic [5:0]          cnt;
  logic [DIV_D_W-1:0]  dv;
  logic [DIV_D_W-1:0]  rem;
  logic [DIV_D_W:0]    rem_sh;
  logic                fits;

  assign rem_sh = {rem, q[WIDE_W-1]};
  assign fits   = rem_sh >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= n;
      dv  <= d;
      rem <= '0;
    end else if (busy) begin
      rem <= fits ? DIV_D_W'(rem_sh - {1'b0, dv}) : rem_sh[DIV_D_W-1:0];
      q   <= {q[WIDE_W-2:0], fits};
    end
  end

endmodule

@@ src/abt_sqrt.sv @@
// integer square root, one result bit per cycle
`timescale 1ns / 1ps
module abt_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [abt_pkg::WIDE_W-1:0]  v,
  output logic                        done,
  output logic [abt_pkg::WIDE_W-1:0]  root
);
  import abt_pkg::*;

  logic              busy;
  logic [4:0]        cnt;
  logic [WIDE_W-1:0] rv;
  logic [WIDE_W-1:0] bitv;
  logic [WIDE_W:0]   trial;

  assign trial = {1'b0, root} + {1'b0, bitv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rv   <= v;
      root <= '0;
      bitv <= {2'b01, {(WIDE_W-2){1'b0}}};
    end else if (busy) begin
      if ({1'b0, rv} >= trial) begin
        rv   <= WIDE_W'({1'b0, rv} - trial);
        root <= (root >> 1) + bitv;
      end else begin
        root <= root >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

endmodule

@@ src/alpha_beta_target_tracker.sv @@
// top level: alpha-beta tracker sequencer, state and stream ports
`timescale 1ns / 1ps
//
// channel  | dir | handshake          | beat contents
// s        | in  | s_tvalid/s_tready  | one observation
// m        | out | m_tvalid/m_tready  | one track estimate
// cfg      | in  | cfg_valid/cfg_ready| register index and value
//
// one beat in gives one beat out; how long it takes is set by the serial
// multiplier, the divider and the square root, the units that the steps share
// rst clears track state and loads register defaults
// the output register holds a finished beat while the next one is accepted;
// a stalled m side blocks only the final load of the output register
module alpha_beta_target_tracker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // obs_x, obs_y, obs_z, obs_confidence, obs_time_ms, elapsed_us, zero pad
  input  logic [abt_pkg::IN_DATA_W-1:0]     s_tdata,
  // seen
  input  logic [0:0]                        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // est_x, est_y, est_z, vel_x, vel_y, vel_z, distance, confidence_out,
  // since_update_us, last_time_ms, zero pad
  output logic [abt_pkg::OUT_DATA_W-1:0]    m_tdata,
  // visible_now, track_state
  output logic [2:0]                        m_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [abt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [abt_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import abt_pkg::*;

  typedef enum logic [21:0] {
    S_IDLE      = 22'h000001,
    S_PRED_MUL  = 22'h000002,
    S_PRED_DIV  = 22'h000004,
    S_CHECK     = 22'h000008,
    S_GATE_MUL  = 22'h000010,
    S_LIM_MUL   = 22'h000020,
    S_ALPHA_MUL = 22'h000040,
    S_BETA_MUL  = 22'h000080,
    S_K_MUL     = 22'h000100,
    S_VEL_DIV   = 22'h000200,
    S_ACCEPT    = 22'h000400,
    S_REJ_MUL   = 22'h000800,
    S_REJ_DIV   = 22'h001000,
    S_DIST_MUL  = 22'h002000,
    S_SQRT      = 22'h004000,
    S_SEND      = 22'h008000,
    S_SPARE0    = 22'h010000,
    S_SPARE1    = 22'h020000,
    S_SPARE2    = 22'h040000,
    S_SPARE3    = 22'h080000,
    S_SPARE4    = 22'h100000,
    S_SPARE5    = 22'h200000
  } state_t;

  localparam logic [WIDE_W-1:0] US_PER_S  = 64'd1000000;
  localparam logic [WIDE_W-1:0] US_HALF   = 64'd500000;
  localparam logic [WIDE_W-1:0] GAIN_HALF = 64'd32768;
  localparam logic [MUL_B_W-1:0] K_15625  = 32'd15625;

  // config registers
  logic [15:0] alpha_gain, beta_gain;
  logic [30:0] max_innovation;
  logic [23:0] lost_timeout_us, confidence_decay;

  // track state
  logic signed [31:0] pos [3];
  logic signed [31:0] vel [3];
  logic signed [32:0] innov [3];
  logic               has_track, visible_reg;
  logic [1:0]         status_reg;
  logic [16:0]        conf_reg;
  logic [31:0]        coast_time, stamp_reg;

  // latched observation
  logic               seen;
  logic signed [31:0] obs [3];
  logic [16:0]        mc;
  logic [31:0]        ot;
  logic [17:0]        step;

  state_t       state;
  logic [1:0]   ax;
  logic         issued;
  logic [63:0]  sum;

  unit_hs_t          mul_hs, div_hs, sqrt_hs;
  logic [WIDE_W-1:0] mul_a, mul_prod, div_n, div_q, sqrt_root;
  logic [MUL_B_W-1:0] mul_b;
  logic [DIV_D_W-1:0] div_d;

  // input unpack
  logic [16:0] in_conf;
  logic [19:0] in_el;
  logic [17:0] in_step;
  assign in_conf = s_tdata[112:96];
  assign in_el   = s_tdata[164:145];
  assign in_step = (in_el >= 20'd101 && in_el <= 20'd200000) ? in_el[17:0] : 18'd10000;

  function automatic logic [31:0] abs32(input logic signed [31:0] x);
    abs32 = x[31] ? 32'(-x) : 32'(x);
  endfunction

  // add a signed magnitude to a position or velocity, saturating
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] base,
                                                 input logic [63:0] mag,
                                                 input logic neg);
    logic [33:0]        mcl;
    logic signed [35:0] s;
    mcl = (|mag[63:33]) ? {1'b1, 33'd0} : mag[33:0];
    s   = 36'(base) + (neg ? -36'($signed({2'b00, mcl})) : 36'($signed({2'b00, mcl})));
    if (s > 36'sd2147483647)       sat_add = 32'sh7fffffff;
    else if (s < -36'sd2147483648) sat_add = 32'sh80000000;
    else                           sat_add = s[31:0];
  endfunction

  logic [32:0] innov_mag;
  logic        gate_over;
  logic [32:0] lt_sum;
  logic [31:0] lt_sat;
  logic [16:0] conf_dec;

  assign innov_mag = innov[ax][32] ? 33'(-innov[ax]) : 33'(innov[ax]);
  assign gate_over = innov_mag > {2'b00, max_innovation};
  assign lt_sum    = {1'b0, coast_time} + 33'(step);
  assign lt_sat    = lt_sum[32] ? 32'hffffffff : lt_sum[31:0];
  assign conf_dec  = ({47'd0, conf_reg} > div_q) ? 17'(conf_reg - div_q[16:0]) : 17'd0;

  // operand selection for the shared units
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    div_n = '0;
    div_d = '0;
    case (state)
      S_PRED_MUL:  begin mul_a = 64'(abs32(vel[ax])); mul_b = 32'(step); end
      S_GATE_MUL:  begin mul_a = 64'(innov_mag); mul_b = innov_mag[31:0]; end
      S_LIM_MUL:   begin mul_a = 64'(max_innovation); mul_b = 32'(max_innovation); end
      S_ALPHA_MUL: begin mul_a = 64'(innov_mag); mul_b = 32'(alpha_gain); end
      S_BETA_MUL:  begin mul_a = 64'(innov_mag); mul_b = 32'(beta_gain); end
      S_K_MUL:     begin mul_a = mul_prod; mul_b = K_15625; end
      S_REJ_MUL:   begin mul_a = 64'(confidence_decay); mul_b = 32'(step); end
      S_DIST_MUL:  begin mul_a = 64'(abs32(pos[ax])); mul_b = abs32(pos[ax]); end
      S_PRED_DIV, S_REJ_DIV: begin div_n = mul_prod + US_HALF; div_d = US_PER_S[31:0]; end
      S_VEL_DIV:   begin
        div_n = mul_prod + {37'd0, step, 9'd0};
        div_d = {4'd0, step, 10'd0};
      end
      default: ;
    endcase
  end

  assign mul_hs.start = !issued && (state == S_PRED_MUL || state == S_LIM_MUL ||
                        state == S_ALPHA_MUL || state == S_BETA_MUL || state == S_K_MUL ||
                        state == S_REJ_MUL || state == S_DIST_MUL ||
                        (state == S_GATE_MUL && !gate_over));
  assign div_hs.start = !issued && (state == S_PRED_DIV || state == S_VEL_DIV ||
                        state == S_REJ_DIV);
  assign sqrt_hs.start = !issued && state == S_SQRT;

  abt_mul u_mul (.clk, .rst, .start(mul_hs.start), .a(mul_a), .b(mul_b),
                 .done(mul_hs.done), .prod(mul_prod));
  abt_div u_div (.clk, .rst, .start(div_hs.start), .n(div_n), .d(div_d),
                 .done(div_hs.done), .q(div_q));
  abt_sqrt u_sqrt (.clk, .rst, .start(sqrt_hs.start), .v(sum),
                   .done(sqrt_hs.done), .root(sqrt_root));

  assign s_tready  = state == S_IDLE;
  assign cfg_ready = 1'b1;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_gain       <= 16'd36045;
      beta_gain        <= 16'd7864;
      max_innovation   <= 31'd131072;
      lost_timeout_us  <= 24'd1000000;
      confidence_decay <= 24'd52429;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ALPHA:   alpha_gain       <= cfg_data[15:0];
        CFG_BETA:    beta_gain        <= cfg_data[15:0];
        CFG_GATE:    max_innovation   <= cfg_data;
        CFG_TIMEOUT: lost_timeout_us  <= cfg_data[23:0];
        CFG_DECAY:   confidence_decay <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // latched observation fields
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      seen   <= s_tuser[0];
      obs[0] <= s_tdata[31:0];
      obs[1] <= s_tdata[63:32];
      obs[2] <= s_tdata[95:64];
      mc     <= (in_conf == 17'd0 || in_conf > 17'd65536) ? 17'd65536 : in_conf;
      ot     <= s_tdata[144:113];
      step   <= in_step;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      issued      <= 1'b0;
      ax          <= '0;
      sum         <= '0;
      has_track   <= 1'b0;
      status_reg  <= TRK_LOST;
      visible_reg <= 1'b0;
      conf_reg    <= '0;
      coast_time  <= 32'hffffffff;
      stamp_reg   <= '0;
      m_tvalid    <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        pos[i] <= '0;
        vel[i] <= '0;
      end
    end else begin
      if (state == S_SEND && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (mul_hs.start || div_hs.start || sqrt_hs.start) issued <= 1'b1;
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            ax    <= '0;
            state <= has_track ? S_PRED_MUL : S_CHECK;
          end
        end
        S_PRED_MUL: if (mul_hs.done) begin issued <= 1'b0; state <= S_PRED_DIV; end
        S_PRED_DIV: begin
          if (div_hs.done) begin
            issued  <= 1'b0;
            pos[ax] <= sat_add(pos[ax], div_q, vel[ax][31]);
            if (ax == 2'd2) begin ax <= '0; state <= S_CHECK; end
            else begin ax <= ax + 2'd1; state <= S_PRED_MUL; end
          end
        end
        S_CHECK: begin
          if (!seen) state <= S_REJ_MUL;
          else if (!has_track || status_reg == TRK_LOST) begin
            for (int i = 0; i < 3; i++) begin
              pos[i] <= obs[i];
              vel[i] <= '0;
            end
            has_track <= 1'b1;
            state     <= S_ACCEPT;
          end else begin
            for (int i = 0; i < 3; i++) innov[i] <= 33'(obs[i]) - 33'(pos[i]);
            sum   <= '0;
            ax    <= '0;
            state <= S_GATE_MUL;
          end
        end
        S_GATE_MUL: begin
          if (!issued && gate_over) state <= S_REJ_MUL;
          else if (mul_hs.done) begin
            issued <= 1'b0;
            sum    <= sum + mul_prod;
            if (ax == 2'd2) begin ax <= '0; state <= S_LIM_MUL; end
            else ax <= ax + 2'd1;
          end
        end
        S_LIM_MUL: begin
          if (mul_hs.done) begin
            issued <= 1'b0;
            state  <= (sum > mul_prod) ? S_REJ_MUL : S_ALPHA_MUL;
          end
        end
        S_ALPHA_MUL: begin
          if (mul_hs.done) begin
            issued  <= 1'b0;
            pos[ax] <= sat_add(pos[ax], (mul_prod + GAIN_HALF) >> 16, innov[ax][32]);
            state   <= S_BETA_MUL;
          end
        end
        S_BETA_MUL: if (mul_hs.done) begin issued <= 1'b0; state <= S_K_MUL; end
        S_K_MUL:    if (mul_hs.done) begin issued <= 1'b0; state <= S_VEL_DIV; end
        S_VEL_DIV: begin
          if (div_hs.done) begin
            issued  <= 1'b0;
            vel[ax] <= sat_add(vel[ax], div_q, innov[ax][32]);
            if (ax == 2'd2) begin ax <= '0; state <= S_ACCEPT; end
            else begin ax <= ax + 2'd1; state <= S_ALPHA_MUL; end
          end
        end
        S_ACCEPT: begin
          visible_reg <= 1'b1;
          status_reg  <= TRK_TRACKING;
          conf_reg    <= mc;
          stamp_reg   <= ot;
          coast_time  <= '0;
          ax          <= '0;
          sum         <= '0;
          state       <= S_DIST_MUL;
        end
        S_REJ_MUL: if (mul_hs.done) begin issued <= 1'b0; state <= S_REJ_DIV; end
        S_REJ_DIV: begin
          if (div_hs.done) begin
            issued      <= 1'b0;
            visible_reg <= 1'b0;
            coast_time  <= lt_sat;
            conf_reg    <= conf_dec;
            if (has_track && lt_sat < 32'(lost_timeout_us)) status_reg <= TRK_COASTING;
            else begin
              status_reg <= TRK_LOST;
              has_track  <= 1'b0;
              for (int i = 0; i < 3; i++) vel[i] <= '0;
            end
            ax    <= '0;
            sum   <= '0;
            state <= S_DIST_MUL;
          end
        end
        S_DIST_MUL: begin
          if (mul_hs.done) begin
            issued <= 1'b0;
            sum    <= sum + mul_prod;
            if (ax == 2'd2) begin ax <= '0; state <= S_SQRT; end
            else ax <= ax + 2'd1;
          end
        end
        S_SQRT: if (sqrt_hs.done) begin issued <= 1'b0; state <= S_SEND; end
        S_SEND: begin
          // load the output register once the previous beat has left
          if (!m_tvalid || m_tready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (state == S_SEND && (!m_tvalid || m_tready)) begin
      m_tuser <= {status_reg, visible_reg};
      m_tdata <= {7'd0, stamp_reg, coast_time, conf_reg,
                  (|sqrt_root[63:32]) ? 32'hffffffff : sqrt_root[31:0],
                  vel[2], vel[1], vel[0], pos[2], pos[1], pos[0]};
    end
  end

  // every unit start sets issued, so no unit is restarted while a result is still expected
  assert property (@(posedge clk) disable iff (rst)
    (mul_hs.start || div_hs.start || sqrt_hs.start) |=> issued)
    else $error("unit started without tracking");

  // a lost track reports zero velocity
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[2:1] == TRK_LOST) |-> m_tdata[191:96] == '0)
    else $error("lost track with nonzero velocity");

  // an accepted observation always means tracking
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> m_tuser[2:1] == TRK_TRACKING)
    else $error("visible but not tracking");

  // an accepted observation resets the coasting time
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> m_tdata[272:241] == '0)
    else $error("visible with nonzero coasting time");

endmodule

@@ tb/alpha_beta_target_tracker_tb.sv @@
// self-checking testbench for the alpha-beta target tracker
`timescale 1ns / 1ps
module alpha_beta_target_tracker_tb;
  import abt_pkg::*;

  // observation fields as carried on the s side
  typedef struct {
    bit              seen;
    logic [31:0]     ox, oy, oz;
    logic [16:0]     oconf;
    logic [31:0]     otime;
    logic [19:0]     elapsed;
  } obs_t;

  // one track estimate as carried on the m side
  typedef struct {
    logic        vis;
    logic [1:0]  trk;
    logic [31:0] est [3];
    logic [31:0] vel [3];
    logic [31:0] norm;
    logic [16:0] conf;
    logic [31:0] since;
    logic [31:0] stamp;
  } estimate_t;

  // directed row: observation plus an optional typed-in estimate
  typedef struct {
    obs_t      o;
    bit        typed;
    estimate_t e;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic [0:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [2:0] m_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  always #5 clk = ~clk;

  alpha_beta_target_tracker u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // tracker registers and state as the checker sees them
  longint unsigned g_alpha, g_beta, g_gate, g_timeout, g_decay;
  longint trk_pos [3];
  longint trk_vel [3];
  bit trk_live;
  logic [1:0] trk_status;
  bit trk_vis;
  longint unsigned trk_conf, trk_since, trk_stamp;

  estimate_t expected_estimates [$];
  int errors = 0;
  int beats_in = 0, beats_out = 0, accepted_cnt = 0, dropped_cnt = 0;
  int idle_cycles = 0;
  bit quiet_stretch = 1'b0;
  bit stim_done = 1'b0;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // nearest, ties away from zero
  function automatic longint round_div(longint n, longint unsigned d);
    longint unsigned m, q;
    m = n < 0 ? longint'(-n) : n;
    q = (m + d / 2) / d;
    return n < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  task automatic tracker_reset_state();
    g_alpha = 36045; g_beta = 7864; g_gate = 131072;
    g_timeout = 1000000; g_decay = 52429;
    for (int i = 0; i < 3; i++) begin
      trk_pos[i] = 0;
      trk_vel[i] = 0;
    end
    trk_live = 0; trk_status = TRK_LOST; trk_vis = 0;
    trk_conf = 0; trk_since = 64'hFFFF_FFFF; trk_stamp = 0;
  endtask

  // advance the track by one observation and return the estimate it gives
  function automatic estimate_t track_step(obs_t o);
    estimate_t e;
    longint unsigned stp, mc, sum, lim, m, lt, dec, sq;
    longint obs [3];
    longint inn [3];
    bit ok;
    stp = (o.elapsed >= 101 && o.elapsed <= 200000) ? o.elapsed : 10000;
    ok = o.seen;
    for (int i = 0; i < 3; i++) inn[i] = 0;
    obs[0] = longint'(signed'(o.ox));
    obs[1] = longint'(signed'(o.oy));
    obs[2] = longint'(signed'(o.oz));
    if (trk_live)
      for (int i = 0; i < 3; i++)
        trk_pos[i] = clamp32(trk_pos[i] + round_div(trk_vel[i] * longint'(stp), 1000000));
    if (ok) begin
      mc = (o.oconf == 0 || o.oconf > 65536) ? 65536 : o.oconf;
      if (!trk_live || trk_status == TRK_LOST) begin
        // seed a fresh track at the observation
        for (int i = 0; i < 3; i++) begin
          trk_pos[i] = obs[i];
          trk_vel[i] = 0;
        end
        trk_live = 1;
      end else begin
        sum = 0;
        lim = g_gate;
        for (int i = 0; i < 3; i++) begin
          inn[i] = obs[i] - trk_pos[i];
          m = inn[i] < 0 ? longint'(-inn[i]) : inn[i];
          if (m > lim) ok = 0;
          else sum += m * m;
        end
        if (ok && sum > lim * lim) ok = 0;
      end
      if (ok) begin
        for (int i = 0; i < 3; i++) begin
          trk_pos[i] = clamp32(trk_pos[i] + round_div(inn[i] * longint'(g_alpha), 65536));
          trk_vel[i] = clamp32(trk_vel[i] +
                       round_div(inn[i] * longint'(g_beta) * 15625, stp * 1024));
        end
        trk_vis = 1; trk_status = TRK_TRACKING; trk_conf = mc;
        trk_stamp = o.otime; trk_since = 0;
      end
    end
    if (!ok) begin
      lt = trk_since + stp;
      dec = (g_decay * stp + 500000) / 1000000;
      trk_vis = 0;
      trk_since = lt > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : lt;
      trk_conf = trk_conf > dec ? trk_conf - dec : 0;
      if (trk_live && trk_since < g_timeout) begin
        trk_status = TRK_COASTING;
      end else begin
        trk_status = TRK_LOST;
        for (int i = 0; i < 3; i++) trk_vel[i] = 0;
        trk_live = 0;
      end
    end
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      m = trk_pos[i] < 0 ? longint'(-trk_pos[i]) : trk_pos[i];
      sq += m * m;
    end
    sq = int_sqrt(sq);
    e.vis = trk_vis; e.trk = trk_status;
    for (int i = 0; i < 3; i++) begin
      e.est[i] = trk_pos[i][31:0];
      e.vel[i] = trk_vel[i][31:0];
    end
    e.norm = sq > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : sq[31:0];
    e.conf = trk_conf[16:0]; e.since = trk_since[31:0]; e.stamp = trk_stamp[31:0];
    return e;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch beat %0d %s: got %h want %h", beats_out, what, got, want);
  endtask

  // random idling: about 7 in 100, none during the quiet stretch
  function automatic bit idle_now();
    return !quiet_stretch && ($urandom_range(99) < 7);
  endfunction

  // ---------------------------------------------------------------- s side
  row_t send_q [$];

  always @(posedge clk) begin
    row_t      r;
    estimate_t p;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        // the predictor always advances; typed rows are checked as typed
        r = send_q.pop_front();
        p = track_step(r.o);
        expected_estimates.push_back(r.typed ? r.e : p);
        beats_in++;
      end
      // decide the next beat without dropping and raising valid in one step
      if (!s_tvalid || s_tready) begin
        if (send_q.size() > 0 && !idle_now()) begin
          s_tvalid <= 1'b1;
          s_tdata <= {3'b0, send_q[0].o.elapsed, send_q[0].o.otime, send_q[0].o.oconf,
                      send_q[0].o.oz, send_q[0].o.oy, send_q[0].o.ox};
          s_tuser <= send_q[0].o.seen;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- m side
  always @(posedge clk) begin
    estimate_t w;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        beats_out++;
        if (expected_estimates.size() == 0) begin
          report("unexpected beat", 32'd0, 32'd0);
        end else begin
          w = expected_estimates.pop_front();
          if (w.vis) accepted_cnt++;
          if (w.trk == TRK_LOST) dropped_cnt++;
          if (m_tuser[0] !== w.vis) report("visible_now", m_tuser[0], w.vis);
          if (m_tuser[2:1] !== w.trk) report("track_state", m_tuser[2:1], w.trk);
          for (int i = 0; i < 3; i++) begin
            if (m_tdata[32*i +: 32] !== w.est[i]) report("est", m_tdata[32*i +: 32], w.est[i]);
            if (m_tdata[96+32*i +: 32] !== w.vel[i])
              report("vel", m_tdata[96+32*i +: 32], w.vel[i]);
          end
          if (m_tdata[223:192] !== w.norm) report("distance", m_tdata[223:192], w.norm);
          if (m_tdata[240:224] !== w.conf) report("confidence", m_tdata[240:224], w.conf);
          if (m_tdata[272:241] !== w.since) report("since_update", m_tdata[272:241], w.since);
          if (m_tdata[304:273] !== w.stamp) report("last_time", m_tdata[304:273], w.stamp);
        end
      end
      m_tready <= !idle_now();
    end
  end

  // ---------------------------------------------------------------- watchdog
  // allow a wide margin for the slowest beat plus stalls
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready) ||
        rst || expected_estimates.size() == 0 && send_q.size() == 0)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("alpha_beta_target_tracker_tb: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------- helpers
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint unsigned val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_ALPHA:   g_alpha = val & 64'hFFFF;
      CFG_BETA:    g_beta = val & 64'hFFFF;
      CFG_GATE:    g_gate = val & 64'h7FFF_FFFF;
      CFG_TIMEOUT: g_timeout = val & 64'hFF_FFFF;
      CFG_DECAY:   g_decay = val & 64'hFF_FFFF;
      default: ;
    endcase
  endtask

  // wait for every outstanding estimate, then a short settle
  task automatic drain();
    while (send_q.size() > 0 || s_tvalid || expected_estimates.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  function automatic obs_t mk(bit sn, longint x, longint y, longint z,
                              int unsigned cf, int unsigned tm, int unsigned el);
    obs_t o;
    o.seen = sn; o.ox = x[31:0]; o.oy = y[31:0]; o.oz = z[31:0];
    o.oconf = cf[16:0]; o.otime = tm; o.elapsed = el[19:0];
    return o;
  endfunction

  // an observation checked against the predictor only
  function automatic row_t as_row(obs_t o);
    row_t r;
    r.o = o;
    r.typed = 0;
    r.e = '{default: 0};
    return r;
  endfunction

  function automatic int unsigned rnd_elapsed();
    case ($urandom_range(9))
      0: return $urandom_range(1048575);
      1: return $urandom_range(100);
      2: return $urandom_range(200001, 1048575);
      3: return $urandom_range(1) ? 101 : 200000;
      default: return $urandom_range(101, 50000);
    endcase
  endfunction

  // full-range noise observation
  function automatic obs_t rnd_noise();
    return mk($urandom_range(1), $urandom(), $urandom(), $urandom(),
              $urandom_range(131071), $urandom(), rnd_elapsed());
  endfunction

  // observation near a moving target so most pass the gate
  longint tgt [3];
  longint tgt_v [3];
  function automatic obs_t rnd_near(int unsigned tm);
    obs_t o;
    longint p [3];
    int unsigned el;
    el = rnd_elapsed();
    for (int i = 0; i < 3; i++) begin
      tgt[i] = tgt[i] + tgt_v[i];
      p[i] = tgt[i] + $signed($urandom_range(40000)) - 20000;
    end
    o = mk($urandom_range(15) != 0, p[0], p[1], p[2],
           $urandom_range(4) == 0 ? $urandom_range(131071) : $urandom_range(65536),
           tm, el);
    return o;
  endfunction

  // ---------------------------------------------------------------- directed table
  row_t rows [$];
  task automatic add(obs_t o, bit typed = 0, estimate_t e = '{default: 0});
    row_t r;
    r.o = o; r.typed = typed; r.e = e;
    rows.push_back(r);
  endtask

  initial begin
    estimate_t e0, g;
    int unsigned tm;
    tracker_reset_state();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // registers at reset values, then the directed table
    e0 = '{default: 0};
    e0.trk = TRK_LOST; e0.since = 32'hFFFF_FFFF;
    foreach (e0.est[i]) begin
      e0.est[i] = 0;
      e0.vel[i] = 0;
    end
    add(mk(0, 0, 0, 0, 0, 0, 0), 1, e0);                 // no track, nothing seen
    e0.vis = 1; e0.trk = TRK_TRACKING; e0.since = 0; e0.conf = 17'd65536;
    e0.stamp = 32'd7;
    e0.est[0] = 32'd65536; e0.norm = 32'd65536;
    add(mk(1, 65536, 0, 0, 0, 7, 10000), 1, e0);          // seed, conf zero means one
    add(mk(1, 98304, 0, 0, 70000, 8, 101));               // small innovation, min step
    add(mk(1, 98304, 16384, 0, 65536, 9, 200000));        // max step
    add(mk(1, 64'sd2000000, 0, 0, 1, 10, 100));           // gated out, step fallback
    add(mk(0, 0, 0, 0, 0, 11, 200001));                   // coast
    add(mk(1, 131072, 0, 0, 131071, 12, 1048575));        // confidence clamp
    add(mk(0, 0, 0, 0, 0, 0, 200000));
    for (int k = 0; k < 5; k++) add(mk(0, 0, 0, 0, 0, 0, 200000)); // timeout, drop
    add(mk(1, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF, 5, 32'hFFFF_FFFF, 0));
    add(mk(1, -64'sh8000_0000, -64'sh8000_0000, -64'sh8000_0000, 0, 0, 0));
    add(mk(1, -64'sh8000_0000, 0, 64'sh7FFF_FFFF, 65536, 1, 1));
    foreach (rows[k]) send_q.push_back(rows[k]);
    drain();

    // extreme gains, wide gate, then random phases
    write_reg(CFG_ALPHA, 65535);
    write_reg(CFG_BETA, 65535);
    write_reg(CFG_GATE, 64'h7FFF_FFFF);
    write_reg(CFG_TIMEOUT, 16777215);
    write_reg(CFG_DECAY, 16777215);
    for (int k = 0; k < 8; k++) send_q.push_back(as_row(rnd_noise()));
    drain();
    write_reg(CFG_ALPHA, 0);
    write_reg(CFG_BETA, 0);
    write_reg(CFG_GATE, 0);
    write_reg(CFG_TIMEOUT, 0);
    write_reg(CFG_DECAY, 0);
    for (int k = 0; k < 6; k++) send_q.push_back(as_row(rnd_near(k)));
    drain();

    tm = 0;
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_ALPHA, $urandom_range(65535));
      write_reg(CFG_BETA, $urandom_range(65535));
      write_reg(CFG_GATE, ph == 7 ? 64'h7FFF_FFFF : $urandom_range(300000, 30000));
      write_reg(CFG_TIMEOUT, $urandom_range(ph == 6 ? 16777215 : 2000000));
      write_reg(CFG_DECAY, $urandom_range(ph == 5 ? 16777215 : 200000));
      quiet_stretch = (ph == 3);
      for (int i = 0; i < 3; i++) begin
        tgt[i] = $signed($urandom_range(2000000)) - 1000000;
        tgt_v[i] = $signed($urandom_range(4000)) - 2000;
      end
      for (int k = 0; k < 240; k++) begin
        tm += $urandom_range(30);
        send_q.push_back(as_row($urandom_range(9) < 8 ? rnd_near(tm) : rnd_noise()));
        if (send_q.size() > 8) wait (send_q.size() <= 4);
      end
      drain();
    end
    quiet_stretch = 0;
    stim_done = 1;

    $display("covered %0d beats in, %0d out: %0d accepted observations, %0d lost results",
             beats_in, beats_out, accepted_cnt, dropped_cnt);
    $display("register settings included both extremes of every field");
    if (errors == 0) begin
      $display("alpha_beta_target_tracker_tb: clean");
    end else begin
      $display("alpha_beta_target_tracker_tb: errors");
    end
    $finish;
  end

endmodule
